// ----- rtl/r4ntt_pkg.sv -----
`default_nettype none
package r4ntt_pkg;

   localparam int CoefWidth    = 16;
   localparam int ModWidth     = 15;
   localparam int ProdWidth    = 2 * CoefWidth;
   localparam int CsrIdxWidth  = 3;
   localparam int NumStages    = 8;

   typedef logic signed [CoefWidth-1:0]   coef_type;
   typedef logic [ModWidth-1:0]           modulus_type;
   typedef logic signed [ProdWidth-1:0]   prod_type;
   typedef logic [CsrIdxWidth-1:0]        csr_index_type;
   typedef logic [CoefWidth-1:0]          csr_data_type;

   localparam csr_index_type CSR_MODULUS    = 3'd0;
   localparam csr_index_type CSR_MOD_INV    = 3'd1;
   localparam csr_index_type CSR_ZETA_OUTER = 3'd2;
   localparam csr_index_type CSR_ZETA_LEFT  = 3'd3;
   localparam csr_index_type CSR_ZETA_RIGHT = 3'd4;

   localparam modulus_type RST_MODULUS    = 15'd3329;
   localparam coef_type    RST_MOD_INV    = -16'sd3327;
   localparam coef_type    RST_ZETA_OUTER = -16'sd758;
   localparam coef_type    RST_ZETA_LEFT  = -16'sd359;
   localparam coef_type    RST_ZETA_RIGHT = -16'sd1517;

endpackage
`default_nettype wire

// ----- rtl/radix4_ntt_butterfly.sv -----
// Channel   Ports                                       Direction  Handshake
// request   start, busy, req_coef_a..req_coef_d         in         start & !busy
// response  rsp_strobe, rsp_out_a..rsp_out_d            out        rsp_strobe, one cycle
// config    csr_we, csr_index, csr_wdata                in         csr_we
//
// One column enters per cycle while busy is low; its result leaves the s8 registers with rsp_strobe.
// The pipeline is two Montgomery layers, each four stages: z*x, low half
// of p*qinv, m*q, then the final subtract with the add/subtract butterfly.
// busy is high only during reset; synchronous reset clears the valid chain
// and loads the register defaults. The receiver cannot stall, so the
// pipeline never holds.
`default_nettype none
module radix4_ntt_butterfly (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire r4ntt_pkg::coef_type      req_coef_a,
   input  wire r4ntt_pkg::coef_type      req_coef_b,
   input  wire r4ntt_pkg::coef_type      req_coef_c,
   input  wire r4ntt_pkg::coef_type      req_coef_d,
   output      logic                     rsp_strobe,
   output      r4ntt_pkg::coef_type      rsp_out_a,
   output      r4ntt_pkg::coef_type      rsp_out_b,
   output      r4ntt_pkg::coef_type      rsp_out_c,
   output      r4ntt_pkg::coef_type      rsp_out_d,
   input  wire logic                     csr_we,
   input  wire r4ntt_pkg::csr_index_type csr_index,
   input  wire r4ntt_pkg::csr_data_type  csr_wdata
);
   import r4ntt_pkg::*;

   modulus_type modulus_ff;
   coef_type    mod_inv_ff, zeta_outer_ff, zeta_left_ff, zeta_right_ff;

   logic [NumStages-1:0] valid_ff, valid_in;
   logic                 accept;

   // layer 1
   coef_type s1_a_ff, s1_b_ff, s2_a_ff, s2_b_ff, s3_a_ff, s3_b_ff;
   prod_type s1_px_ff, s1_py_ff, s2_px_ff, s2_py_ff, s3_px_ff, s3_py_ff;
   prod_type s1_px_in, s1_py_in, s3_mqx_ff, s3_mqy_ff, s3_mqx_in, s3_mqy_in;
   coef_type s2_mx_ff, s2_my_ff, s2_mx_in, s2_my_in;
   prod_type s4_dx, s4_dy;
   coef_type s4_tx, s4_ty;
   coef_type s4_a_ff, s4_b_ff, s4_c_ff, s4_d_ff;
   coef_type s4_a_in, s4_b_in, s4_c_in, s4_d_in;

   // layer 2
   coef_type s5_a_ff, s5_c_ff, s6_a_ff, s6_c_ff, s7_a_ff, s7_c_ff;
   prod_type s5_px_ff, s5_py_ff, s6_px_ff, s6_py_ff, s7_px_ff, s7_py_ff;
   prod_type s5_px_in, s5_py_in, s7_mqx_ff, s7_mqy_ff, s7_mqx_in, s7_mqy_in;
   coef_type s6_mx_ff, s6_my_ff, s6_mx_in, s6_my_in;
   prod_type s8_dx, s8_dy;
   coef_type s8_tx, s8_ty;
   coef_type s8_a_ff, s8_b_ff, s8_c_ff, s8_d_ff;
   coef_type s8_a_in, s8_b_in, s8_c_in, s8_d_in;

   assign busy     = reset;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[NumStages-2:0], accept};

   // layer 1 datapath
   assign s1_px_in  = prod_type'(zeta_outer_ff) * prod_type'(req_coef_c);
   assign s1_py_in  = prod_type'(zeta_outer_ff) * prod_type'(req_coef_d);
   assign s2_mx_in  = coef_type'(s1_px_ff[CoefWidth-1:0] * mod_inv_ff);
   assign s2_my_in  = coef_type'(s1_py_ff[CoefWidth-1:0] * mod_inv_ff);
   assign s3_mqx_in = prod_type'(s2_mx_ff) * prod_type'($signed({1'b0, modulus_ff}));
   assign s3_mqy_in = prod_type'(s2_my_ff) * prod_type'($signed({1'b0, modulus_ff}));
   assign s4_dx     = s3_px_ff - s3_mqx_ff;
   assign s4_dy     = s3_py_ff - s3_mqy_ff;
   assign s4_tx     = s4_dx[ProdWidth-1:CoefWidth];
   assign s4_ty     = s4_dy[ProdWidth-1:CoefWidth];
   assign s4_a_in   = s3_a_ff + s4_tx;
   assign s4_c_in   = s3_a_ff - s4_tx;
   assign s4_b_in   = s3_b_ff + s4_ty;
   assign s4_d_in   = s3_b_ff - s4_ty;

   // layer 2 datapath
   assign s5_px_in  = prod_type'(zeta_left_ff) * prod_type'(s4_b_ff);
   assign s5_py_in  = prod_type'(zeta_right_ff) * prod_type'(s4_d_ff);
   assign s6_mx_in  = coef_type'(s5_px_ff[CoefWidth-1:0] * mod_inv_ff);
   assign s6_my_in  = coef_type'(s5_py_ff[CoefWidth-1:0] * mod_inv_ff);
   assign s7_mqx_in = prod_type'(s6_mx_ff) * prod_type'($signed({1'b0, modulus_ff}));
   assign s7_mqy_in = prod_type'(s6_my_ff) * prod_type'($signed({1'b0, modulus_ff}));
   assign s8_dx     = s7_px_ff - s7_mqx_ff;
   assign s8_dy     = s7_py_ff - s7_mqy_ff;
   assign s8_tx     = s8_dx[ProdWidth-1:CoefWidth];
   assign s8_ty     = s8_dy[ProdWidth-1:CoefWidth];
   assign s8_a_in   = s7_a_ff + s8_tx;
   assign s8_b_in   = s7_a_ff - s8_tx;
   assign s8_c_in   = s7_c_ff + s8_ty;
   assign s8_d_in   = s7_c_ff - s8_ty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         modulus_ff    <= RST_MODULUS;
         mod_inv_ff    <= RST_MOD_INV;
         zeta_outer_ff <= RST_ZETA_OUTER;
         zeta_left_ff  <= RST_ZETA_LEFT;
         zeta_right_ff <= RST_ZETA_RIGHT;
      end else begin
         valid_ff <= valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODULUS:    modulus_ff    <= csr_wdata[ModWidth-1:0];
               CSR_MOD_INV:    mod_inv_ff    <= coef_type'(csr_wdata);
               CSR_ZETA_OUTER: zeta_outer_ff <= coef_type'(csr_wdata);
               CSR_ZETA_LEFT:  zeta_left_ff  <= coef_type'(csr_wdata);
               CSR_ZETA_RIGHT: zeta_right_ff <= coef_type'(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_a_ff   <= req_coef_a;
      s1_b_ff   <= req_coef_b;
      s1_px_ff  <= s1_px_in;
      s1_py_ff  <= s1_py_in;
      s2_a_ff   <= s1_a_ff;
      s2_b_ff   <= s1_b_ff;
      s2_px_ff  <= s1_px_ff;
      s2_py_ff  <= s1_py_ff;
      s2_mx_ff  <= s2_mx_in;
      s2_my_ff  <= s2_my_in;
      s3_a_ff   <= s2_a_ff;
      s3_b_ff   <= s2_b_ff;
      s3_px_ff  <= s2_px_ff;
      s3_py_ff  <= s2_py_ff;
      s3_mqx_ff <= s3_mqx_in;
      s3_mqy_ff <= s3_mqy_in;
      s4_a_ff   <= s4_a_in;
      s4_b_ff   <= s4_b_in;
      s4_c_ff   <= s4_c_in;
      s4_d_ff   <= s4_d_in;
      s5_a_ff   <= s4_a_ff;
      s5_c_ff   <= s4_c_ff;
      s5_px_ff  <= s5_px_in;
      s5_py_ff  <= s5_py_in;
      s6_a_ff   <= s5_a_ff;
      s6_c_ff   <= s5_c_ff;
      s6_px_ff  <= s5_px_ff;
      s6_py_ff  <= s5_py_ff;
      s6_mx_ff  <= s6_mx_in;
      s6_my_ff  <= s6_my_in;
      s7_a_ff   <= s6_a_ff;
      s7_c_ff   <= s6_c_ff;
      s7_px_ff  <= s6_px_ff;
      s7_py_ff  <= s6_py_ff;
      s7_mqx_ff <= s7_mqx_in;
      s7_mqy_ff <= s7_mqy_in;
      s8_a_ff   <= s8_a_in;
      s8_b_ff   <= s8_b_in;
      s8_c_ff   <= s8_c_in;
      s8_d_ff   <= s8_d_in;
   end

   assign rsp_strobe = valid_ff[NumStages-1];
   assign rsp_out_a  = s8_a_ff;
   assign rsp_out_b  = s8_b_ff;
   assign rsp_out_c  = s8_c_ff;
   assign rsp_out_d  = s8_d_ff;

   a_word_returns: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##8 rsp_strobe)
      else $error("accepted word did not come out after eight cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 8))
      else $error("response strobe without a matching request");

   a_zeta_write: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == CSR_ZETA_OUTER) |=> zeta_outer_ff == $past(csr_wdata))
      else $error("outer twiddle write lost");

   a_modulus_hold: assert property (@(posedge clock) disable iff (reset)
      !(csr_we && csr_index == CSR_MODULUS) |=> $stable(modulus_ff))
      else $error("modulus changed without a write");

endmodule
`default_nettype wire
